>>> rtl/slspan_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slspan_pkg
// Shared constants and types for the scanline span filter.
// ----------------------------------------------------------------------------
package slspan_pkg;

    // coordinate width used for arithmetic, port width is fixed
    localparam int COORD_BITS    = 32;
    localparam int XW            = 32;
    localparam int WIND_BITS     = 16;
    localparam int MAX_ROW_SPANS = 4096;
    localparam int CNT_BITS      = $clog2(MAX_ROW_SPANS + 1);
    localparam int OUT_CNT_W     = 13;

    // stream payload widths
    localparam int S_TDATA_W = 2 * XW;
    localparam int M_FIELD_W = 2 * XW + OUT_CNT_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // input item kinds
    localparam logic ACT_PAIR    = 1'b0;
    localparam logic ACT_ROW_END = 1'b1;

    // fill rule codes
    localparam logic RULE_EVEN_ODD = 1'b0;
    localparam logic RULE_NONZERO  = 1'b1;

    typedef struct packed {
        logic                        span_valid;
        logic signed [XW-1:0]        span_left;
        logic signed [XW-1:0]        span_right;
        logic                        row_last;
        logic        [OUT_CNT_W-1:0] row_span_count;
    } t_result;

    // up to two results from one item, first slot used first
    typedef struct packed {
        logic    has0;
        t_result res0;
        logic    has1;
        t_result res1;
    } t_res_pair;

endpackage

>>> rtl/scanline_fill_rule_span_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_fill_rule_span_filter
// Groups sorted scanline intersections into filled spans under the even-odd
// or nonzero rule, merges overlapping spans and reports spans per row.
// ----------------------------------------------------------------------------
// Takes one intersection or end-of-row transfer per cycle while the output
// buffer has room. Each item passes an input register, one pass of compare/add
// logic that updates the row state, and lands in a two-slot output buffer. An
// intersection yields zero or one span; an end-of-row item yields one or two
// results (the last with tlast and the row count), and when it yields two the
// next item waits while the second result leaves the buffer. Sustained rate is
// one item per cycle as long as the output side takes one result per cycle and
// no row end yields two. The user must write fill_rule through the
// configuration port only while the stream is idle; the block does not enforce it.
module scanline_fill_rule_span_filter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration: fill_rule
    input  logic                             i_cfg_wr_en,
    input  logic                             i_cfg_wr_data,
    // input stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [slspan_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // left_x, right_x
    input  logic                             i_s_axis_tuser,  // action
    // result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [slspan_pkg::M_TDATA_W-1:0] o_m_axis_tdata,  // span_left, span_right,
                                                              // row_span_count, zero pad
    output logic                             o_m_axis_tuser,  // span_valid
    output logic                             o_m_axis_tlast   // row_last
);

    logic                  room;
    logic                  push;
    slspan_pkg::t_res_pair pair;
    slspan_pkg::t_result   out_res;

    slspan_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_s_axis_tvalid),
        .i_in_action   (i_s_axis_tuser),
        .i_in_data     (i_s_axis_tdata),
        .i_room        (room),
        .o_in_ready    (o_s_axis_tready),
        .o_push        (push),
        .o_pair        (pair)
    );

    slspan_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pair      (pair),
        .i_out_ready (i_m_axis_tready),
        .o_room      (room),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_res   (out_res)
    );

    // result packing
    assign o_m_axis_tdata = slspan_pkg::M_TDATA_W'({out_res.row_span_count,
                                                    out_res.span_right,
                                                    out_res.span_left});
    assign o_m_axis_tuser = out_res.span_valid;
    assign o_m_axis_tlast = out_res.row_last;

endmodule

>>> rtl/slspan_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slspan_core
// Input register, row state and the single-pass span update logic.
// ----------------------------------------------------------------------------
module slspan_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic                             i_cfg_wr_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_action,
    input  logic [slspan_pkg::S_TDATA_W-1:0] i_in_data,
    input  logic                             i_room,
    output logic                             o_in_ready,
    output logic                             o_push,
    output slspan_pkg::t_res_pair            o_pair
);

    localparam int XW = slspan_pkg::XW;
    localparam int WB = slspan_pkg::WIND_BITS;
    localparam int CB = slspan_pkg::CNT_BITS;

    // input register
    logic                 r_in_valid;
    logic                 r_in_action;
    logic                 r_in_dir;
    logic signed [XW-1:0] r_in_lx;
    logic signed [XW-1:0] r_in_rx;

    // configuration and row state
    logic                 r_fill_rule;
    logic                 r_group_open, n_group_open;
    logic signed [XW-1:0] r_group_left, n_group_left;
    logic signed [XW-1:0] r_group_right, n_group_right;
    logic [WB-1:0]        r_winding, n_winding;
    logic                 r_held_valid, n_held_valid;
    logic signed [XW-1:0] r_held_left, n_held_left;
    logic signed [XW-1:0] r_held_right, n_held_right;
    logic [CB-1:0]        r_count, n_count;

    slspan_pkg::t_res_pair n_pair;
    slspan_pkg::t_result   fin_res;

    logic                 proc;
    logic                 do_close;
    logic signed [XW-1:0] cl_l, cl_r, l_raised, gr_max;
    logic [WB-1:0]        w_upd;
    logic [CB-1:0]        cnt_fin;

    // saturating span count
    function automatic logic [CB-1:0] count_inc(input logic [CB-1:0] c);
        return (c < CB'(slspan_pkg::MAX_ROW_SPANS)) ? c + CB'(1) : c;
    endfunction

    assign proc       = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || proc;
    assign o_push     = proc;
    assign o_pair     = n_pair;

    // span update for the item in the input register
    always_comb begin
        n_group_open  = r_group_open;
        n_group_left  = r_group_left;
        n_group_right = r_group_right;
        n_winding     = r_winding;
        n_held_valid  = r_held_valid;
        n_held_left   = r_held_left;
        n_held_right  = r_held_right;
        n_count       = r_count;
        n_pair        = '0;
        fin_res       = '0;
        cnt_fin       = r_count;
        do_close      = 1'b0;
        cl_l          = r_group_left;
        cl_r          = r_group_right;
        l_raised      = r_group_left;

        gr_max = (r_in_rx > r_group_right) ? r_in_rx : r_group_right;
        if (r_fill_rule == slspan_pkg::RULE_NONZERO) begin
            w_upd = r_winding + (r_in_dir ? {WB{1'b1}} : WB'(1));
        end else begin
            w_upd = r_winding ^ WB'(1);
        end

        // intersection: open a group or advance its winding
        if (r_in_action == slspan_pkg::ACT_PAIR) begin
            if (!r_group_open) begin
                n_group_open  = 1'b1;
                n_group_left  = {r_in_lx[XW-1:1], 1'b0};
                n_group_right = r_in_rx;
                if (r_fill_rule == slspan_pkg::RULE_NONZERO && r_in_dir) begin
                    n_winding = {WB{1'b1}};
                end else begin
                    n_winding = WB'(1);
                end
            end else begin
                n_group_right = gr_max;
                n_winding     = w_upd;
                if (w_upd == '0) begin
                    do_close = 1'b1;
                    cl_r     = gr_max;
                end
            end
        end else if (r_group_open) begin
            do_close = 1'b1;
        end

        // close group: merge into held span, or emit held (if any) and hold a non-empty new one
        if (do_close) begin
            n_group_open = 1'b0;
            n_winding    = '0;
            if (r_held_valid && r_held_right > cl_l) begin
                if (cl_r > r_held_right) begin
                    n_held_right = cl_r;
                end
            end else begin
                l_raised = (!r_held_valid && cl_l < 0) ? '0 : cl_l;
                if (cl_r > l_raised) begin
                    if (r_held_valid) begin
                        n_pair.has0                = 1'b1;
                        n_pair.res0.span_valid     = 1'b1;
                        n_pair.res0.span_left      = r_held_left;
                        n_pair.res0.span_right     = r_held_right;
                        n_count                    = count_inc(r_count);
                    end
                    n_held_valid = 1'b1;
                    n_held_left  = l_raised;
                    n_held_right = cl_r;
                end
            end
        end

        // end of row: flush the held span (or an empty result) with the row count, then clear
        if (r_in_action == slspan_pkg::ACT_ROW_END) begin
            cnt_fin = n_held_valid ? count_inc(n_count) : n_count;
            fin_res.span_valid     = n_held_valid;
            fin_res.span_left      = n_held_valid ? n_held_left : '0;
            fin_res.span_right     = n_held_valid ? n_held_right : '0;
            fin_res.row_last       = 1'b1;
            fin_res.row_span_count = slspan_pkg::OUT_CNT_W'(cnt_fin);
            if (n_pair.has0) begin
                n_pair.has1 = 1'b1;
                n_pair.res1 = fin_res;
            end else begin
                n_pair.has0 = 1'b1;
                n_pair.res0 = fin_res;
            end
            n_group_open  = 1'b0;
            n_group_left  = '0;
            n_group_right = '0;
            n_winding     = '0;
            n_held_valid  = 1'b0;
            n_held_left   = '0;
            n_held_right  = '0;
            n_count       = '0;
        end
    end

    // input register, configuration and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_fill_rule   <= slspan_pkg::RULE_NONZERO;
            r_group_open  <= 1'b0;
            r_group_left  <= '0;
            r_group_right <= '0;
            r_winding     <= '0;
            r_held_valid  <= 1'b0;
            r_held_left   <= '0;
            r_held_right  <= '0;
            r_count       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_fill_rule <= i_cfg_wr_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (proc) begin
                r_group_open  <= n_group_open;
                r_group_left  <= n_group_left;
                r_group_right <= n_group_right;
                r_winding     <= n_winding;
                r_held_valid  <= n_held_valid;
                r_held_left   <= n_held_left;
                r_held_right  <= n_held_right;
                r_count       <= n_count;
            end
        end
    end

    // input payload, coordinates sign extended from the coordinate width
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_action <= i_in_action;
            r_in_dir    <= i_in_data[0];
            r_in_lx     <= XW'($signed(i_in_data[slspan_pkg::COORD_BITS-1:0]));
            r_in_rx     <= XW'($signed(i_in_data[XW +: slspan_pkg::COORD_BITS]));
        end
    end

endmodule

>>> rtl/slspan_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slspan_obuf
// Two-slot result buffer: output register plus one slot for a second result.
// ----------------------------------------------------------------------------
module slspan_obuf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  slspan_pkg::t_res_pair i_pair,
    input  logic                  i_out_ready,
    output logic                  o_room,
    output logic                  o_out_valid,
    output slspan_pkg::t_result   o_out_res
);

    logic                r_v0, r_v1;
    slspan_pkg::t_result r_d0, r_d1;
    logic                pop;

    assign pop         = r_v0 && i_out_ready;
    // both slots free after this cycle
    assign o_room      = !r_v1 && (!r_v0 || i_out_ready);
    assign o_out_valid = r_v0;
    assign o_out_res   = r_d0;

    // slot valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (i_push) begin
            r_v0 <= i_pair.has0;
            r_v1 <= i_pair.has1;
        end else if (pop) begin
            r_v0 <= r_v1;
            r_v1 <= 1'b0;
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_d0 <= i_pair.res0;
            r_d1 <= i_pair.res1;
        end else if (pop) begin
            r_d0 <= r_d1;
        end
    end

endmodule

>>> rtl/slspan_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slspan_check
// Port-level checks for the scanline span filter, bound to the top level.
// ----------------------------------------------------------------------------
module slspan_check (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [slspan_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input logic                             o_m_axis_tuser,
    input logic                             o_m_axis_tlast
);

    localparam int XW = slspan_pkg::XW;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
            && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // span left is even on every filled span
    a_left_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> !o_m_axis_tdata[0])
        else $error("odd span left");

    // empty result only at row end, with zero coordinates
    a_empty_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
            o_m_axis_tlast && o_m_axis_tdata[2*XW-1:0] == '0)
        else $error("empty result not at row end");

    // count shown only on the last result of a row
    a_count_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |->
            o_m_axis_tdata[2*XW +: slspan_pkg::OUT_CNT_W] == '0)
        else $error("row count outside row end");

endmodule

bind scanline_fill_rule_span_filter slspan_check u_slspan_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
